>>> rtl/depth_to_color_mapper_assert.svh
// assertion macros shared by the depth to color mapper modules
`ifndef DEPTH_TO_COLOR_MAPPER_ASSERT_SVH
`define DEPTH_TO_COLOR_MAPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define DTC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed");
`define DTC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("assertion failed");
`else
`define DTC_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/dtc_pkg.sv
// types and constants of the depth to color mapper
package dtc_pkg;

   localparam int DEPTH_W    = 14;
   localparam int MARGIN_W   = 10;
   localparam int EXT_W      = 16;
   localparam int OFF_W      = 15;
   localparam int NUM_W      = 31;
   localparam int QUO_W      = 17;
   localparam int WAVE_W     = 18;
   localparam int DIST_W     = 15;
   localparam int RAMPX_W    = DIST_W + 8;
   localparam int RECIP_W    = 32;
   localparam int FACSUM_W   = 18;
   localparam int FACNUM_W   = FACSUM_W + 8;
   localparam int INT_W      = 17;
   localparam int PROD_W     = 2 * INT_W;
   localparam int BYTEP_W    = PROD_W + 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // reciprocal multiply shift, exact for every numerator seen here
   localparam int RECIP_SHIFT = 36;

   localparam int FRONT_STAGES = 2;
   localparam int DIV_STAGES   = QUO_W;
   localparam int SHADE_STAGES = 5;
   localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + SHADE_STAGES;

   // wavelengths in 1/256 nm
   localparam logic [WAVE_W-1:0] W_350 = WAVE_W'(350 * 256);
   localparam logic [WAVE_W-1:0] W_420 = WAVE_W'(420 * 256);
   localparam logic [WAVE_W-1:0] W_440 = WAVE_W'(440 * 256);
   localparam logic [WAVE_W-1:0] W_490 = WAVE_W'(490 * 256);
   localparam logic [WAVE_W-1:0] W_510 = WAVE_W'(510 * 256);
   localparam logic [WAVE_W-1:0] W_580 = WAVE_W'(580 * 256);
   localparam logic [WAVE_W-1:0] W_645 = WAVE_W'(645 * 256);
   localparam logic [WAVE_W-1:0] W_680 = WAVE_W'(680 * 256);
   localparam logic [WAVE_W-1:0] W_750 = WAVE_W'(750 * 256);

   localparam logic [QUO_W-1:0]    QUO_MAX  = QUO_W'(400 * 256);
   localparam logic [INT_W-1:0]    ONE_Q16  = INT_W'(65536);
   localparam logic [FACSUM_W-1:0] FAC_BASE = FACSUM_W'(3 * 17920);

   localparam logic [RECIP_W-1:0] RECIP_90  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd89) / 64'd90);
   localparam logic [RECIP_W-1:0] RECIP_50  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd49) / 64'd50);
   localparam logic [RECIP_W-1:0] RECIP_20  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20);
   localparam logic [RECIP_W-1:0] RECIP_70  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd69) / 64'd70);
   localparam logic [RECIP_W-1:0] RECIP_65  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd64) / 64'd65);
   localparam logic [RECIP_W-1:0] RECIP_700 =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd699) / 64'd700);

   localparam logic [7:0] BYTE_MAX = 8'hFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FAR    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN = CSR_IDX_W'(3);

   localparam logic [DEPTH_W-1:0]  NEAR_RST   = DEPTH_W'(0);
   localparam logic [DEPTH_W-1:0]  FAR_RST    = DEPTH_W'(4095);
   localparam logic                MODE_RST   = 1'b1;
   localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(50);

   typedef enum logic [1:0] {
      BAND_BLUE,
      BAND_GREEN,
      BAND_RED
   } band_type;

   typedef struct packed {
      logic                last;
      logic                cont;
      logic                in_range;
      band_type            band;
   } side_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]  near_depth;
      logic [DEPTH_W-1:0]  far_depth;
      logic                cont;
      logic [MARGIN_W-1:0] margin;
   } cfg_type;

endpackage

>>> rtl/depth_to_color_mapper.sv
// depth_to_color_mapper: turns one depth sample into one BGR pixel per request
// a request passes from the accepting edge through dtc_front, dtc_divider and dtc_shade to the rsp_valid strobe
// throughput: one request every cycle, sustained, busy is low outside reset
// the 17-stage divider (one quotient bit per stage) sets most of the latency
// synchronous reset clears all pipeline valid bits and loads register defaults
// each result stays on rsp_ for one cycle; the receiver cannot stall the pipeline
`include "depth_to_color_mapper_assert.svh"
module depth_to_color_mapper (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dtc_pkg::DEPTH_W-1:0]      req_depth,
   input  logic                             req_frame_last_in,
   output logic                             rsp_valid,
   output logic [7:0]                       rsp_blue,
   output logic [7:0]                       rsp_green,
   output logic [7:0]                       rsp_red,
   output logic                             rsp_frame_last_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dtc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dtc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dtc_pkg::*;

   logic                accept;
   logic                csr_write;

   logic [DEPTH_W-1:0]  near_in, near_ff;
   logic [DEPTH_W-1:0]  far_in, far_ff;
   logic                mode_in, mode_ff;
   logic [MARGIN_W-1:0] margin_in, margin_ff;
   cfg_type             cfg;

   logic                front_valid;
   logic [NUM_W-1:0]    front_num;
   logic [OFF_W-1:0]    front_span;
   side_type            front_side;

   logic                div_valid;
   logic [QUO_W-1:0]    div_quo;
   side_type            div_side;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      near_in   = near_ff;
      far_in    = far_ff;
      mode_in   = mode_ff;
      margin_in = margin_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_NEAR:   near_in   = csr_wdata[DEPTH_W-1:0];
            CSR_FAR:    far_in    = csr_wdata[DEPTH_W-1:0];
            CSR_MODE:   mode_in   = csr_wdata[0];
            CSR_MARGIN: margin_in = csr_wdata[MARGIN_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff   <= NEAR_RST;
         far_ff    <= FAR_RST;
         mode_ff   <= MODE_RST;
         margin_ff <= MARGIN_RST;
      end else begin
         near_ff   <= near_in;
         far_ff    <= far_in;
         mode_ff   <= mode_in;
         margin_ff <= margin_in;
      end
   end

   always_comb begin
      cfg.near_depth = near_ff;
      cfg.far_depth  = far_ff;
      cfg.cont       = mode_ff;
      cfg.margin     = margin_ff;
   end

   dtc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_depth  (req_depth),
      .in_last   (req_frame_last_in),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_num   (front_num),
      .out_span  (front_span),
      .out_side  (front_side)
   );

   dtc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_num    (front_num),
      .in_span   (front_span),
      .in_side   (front_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   dtc_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_quo    (div_quo),
      .in_side   (div_side),
      .out_valid (rsp_valid),
      .out_blue  (rsp_blue),
      .out_green (rsp_green),
      .out_red   (rsp_red),
      .out_last  (rsp_frame_last_out)
   );

   // every accepted request comes out as an rsp_valid strobe, and nothing else does
   `DTC_ASSERT_IMP(a_latency, clock, reset, accept, ##LATENCY rsp_valid)
   `DTC_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, $past(accept, LATENCY))

endmodule

>>> rtl/dtc_front.sv
// range check, discrete band and scaled depth offset (two stages)
module dtc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [dtc_pkg::DEPTH_W-1:0]   in_depth,
   input  logic                          in_last,
   input  dtc_pkg::cfg_type              cfg,
   output logic                          out_valid,
   output logic [dtc_pkg::NUM_W-1:0]     out_num,
   output logic [dtc_pkg::OFF_W-1:0]     out_span,
   output dtc_pkg::side_type             out_side
);
   import dtc_pkg::*;

   logic [EXT_W-1:0] d_ext, n_ext, f_ext, m_ext, dm_sum;
   logic             lo_ok, hi_ok;

   logic             valid1_in, valid1_ff;
   logic [OFF_W-1:0] off1_in, off1_ff;
   logic [OFF_W-1:0] span1_in, span1_ff;
   side_type         side1_in, side1_ff;

   logic             valid2_ff;
   logic [NUM_W-1:0] num2_in, num2_ff;
   logic [OFF_W-1:0] span2_ff;
   side_type         side2_ff;

   always_comb begin
      d_ext  = EXT_W'(in_depth);
      n_ext  = EXT_W'(cfg.near_depth);
      f_ext  = EXT_W'(cfg.far_depth);
      m_ext  = EXT_W'(cfg.margin);
      dm_sum = d_ext + m_ext;
      lo_ok  = (d_ext + EXT_W'(5)) >= n_ext;
      hi_ok  = d_ext <= (f_ext + EXT_W'(5));
      off1_in  = OFF_W'(d_ext + EXT_W'(5) - n_ext);
      span1_in = OFF_W'(f_ext + EXT_W'(10) - n_ext);
      valid1_in = in_valid;
      side1_in.last     = in_last;
      side1_in.cont     = cfg.cont;
      side1_in.in_range = lo_ok && hi_ok;
      // signed thresholds, compared with the margin moved to the depth side
      if (dm_sum >= f_ext) begin
         side1_in.band = BAND_RED;
      end else if (dm_sum <= n_ext) begin
         side1_in.band = BAND_BLUE;
      end else begin
         side1_in.band = BAND_GREEN;
      end
   end

   // offset times 400 nm in 1/256 nm units: 102400 = 2^16 + 2^15 + 2^12
   assign num2_in = (NUM_W'(off1_ff) << 16) + (NUM_W'(off1_ff) << 15)
                  + (NUM_W'(off1_ff) << 12);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      off1_ff  <= off1_in;
      span1_ff <= span1_in;
      side1_ff <= side1_in;
      num2_ff  <= num2_in;
      span2_ff <= span1_ff;
      side2_ff <= side1_ff;
   end

   assign out_valid = valid2_ff;
   assign out_num   = num2_ff;
   assign out_span  = span2_ff;
   assign out_side  = side2_ff;

endmodule

>>> rtl/dtc_divider.sv
// pipelined restoring divider, one quotient bit per stage
`include "depth_to_color_mapper_assert.svh"
module dtc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [dtc_pkg::NUM_W-1:0]     in_num,
   input  logic [dtc_pkg::OFF_W-1:0]     in_span,
   input  dtc_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [dtc_pkg::QUO_W-1:0]     out_quo,
   output dtc_pkg::side_type             out_side
);
   import dtc_pkg::*;

   logic             valid_ff [DIV_STAGES];
   logic [NUM_W-1:0] rem_ff   [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff   [DIV_STAGES];
   logic [OFF_W-1:0] span_ff  [DIV_STAGES];
   side_type         side_ff  [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;

      logic             prev_valid;
      logic [NUM_W-1:0] prev_rem;
      logic [QUO_W-1:0] prev_quo;
      logic [OFF_W-1:0] prev_span;
      side_type         prev_side;
      logic [NUM_W-1:0] trial;
      logic             take;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = in_num;
         assign prev_quo   = '0;
         assign prev_span  = in_span;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
         assign prev_span  = span_ff[k-1];
         assign prev_side  = side_ff[k-1];
      end

      // a zero span only meets a zero offset, whose quotient stays zero
      assign trial  = NUM_W'(prev_span) << BIT;
      assign take   = (prev_span != '0) && (prev_rem >= trial);
      assign rem_in = take ? (prev_rem - trial) : prev_rem;
      assign quo_in = take ? (prev_quo | (QUO_W'(1) << BIT)) : prev_quo;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         quo_ff[k]  <= quo_in;
         span_ff[k] <= prev_span;
         side_ff[k] <= prev_side;
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quo   = quo_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

   // offset never exceeds span inside the range, so the wavelength stays at or below 750 nm
   `DTC_ASSERT_IMP(a_quo_bound, clock, reset, out_valid && out_side.in_range, out_quo <= QUO_MAX)

endmodule

>>> rtl/dtc_shade.sv
// spectral color, edge falloff and byte scaling (five stages)
`include "depth_to_color_mapper_assert.svh"
module dtc_shade (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [dtc_pkg::QUO_W-1:0]     in_quo,
   input  dtc_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [7:0]                    out_blue,
   output logic [7:0]                    out_green,
   output logic [7:0]                    out_red,
   output logic                          out_last
);
   import dtc_pkg::*;

   typedef enum logic [2:0] {
      SEG_VIOLET,
      SEG_BLUE,
      SEG_CYAN,
      SEG_GREEN,
      SEG_YELLOW,
      SEG_RED
   } seg_type;

   // stage 1: segment and factor selection
   logic [WAVE_W-1:0]   wave;
   logic [DIST_W-1:0]   seg_dist, fx;
   logic [FACSUM_W-1:0] fac_sum;

   logic                valid1_ff;
   seg_type             seg1_in, seg1_ff;
   logic [RAMPX_W-1:0]  rampx1_in, rampx1_ff;
   logic [RECIP_W-1:0]  recip1_in, recip1_ff;
   logic [FACNUM_W-1:0] facnum1_in, facnum1_ff;
   logic                full1_in, full1_ff;
   side_type            side1_ff;

   // stage 2: reciprocal products
   logic                          valid2_ff;
   logic [RAMPX_W+RECIP_W-1:0]    ramp2_in, ramp2_ff;
   logic [FACNUM_W+RECIP_W-1:0]   fac2_in, fac2_ff;
   seg_type                       seg2_ff;
   logic                          full2_ff;
   side_type                      side2_ff;

   // stage 3: channel intensities
   logic               valid3_ff;
   logic [INT_W-1:0]   ramp3, fac3_in, fac3_ff;
   logic [INT_W-1:0]   cb3_in, cg3_in, cr3_in, cb3_ff, cg3_ff, cr3_ff;
   side_type           side3_ff;

   // stage 4: intensity times factor
   logic               valid4_ff;
   logic [PROD_W-1:0]  pb4_in, pg4_in, pr4_in, pb4_ff, pg4_ff, pr4_ff;
   side_type           side4_ff;

   // stage 5: bytes
   logic [BYTEP_W-1:0] sb, sg, sr;
   logic [7:0]         blue_in, green_in, red_in;
   logic [7:0]         blue_ff, green_ff, red_ff;
   logic               valid5_ff, last5_ff;

   always_comb begin
      wave = WAVE_W'(in_quo) + W_350;
      if (wave < W_440) begin
         seg1_in = SEG_VIOLET; seg_dist = DIST_W'(W_440 - wave); recip1_in = RECIP_90;
      end else if (wave < W_490) begin
         seg1_in = SEG_BLUE;   seg_dist = DIST_W'(wave - W_440); recip1_in = RECIP_50;
      end else if (wave < W_510) begin
         seg1_in = SEG_CYAN;   seg_dist = DIST_W'(W_510 - wave); recip1_in = RECIP_20;
      end else if (wave < W_580) begin
         seg1_in = SEG_GREEN;  seg_dist = DIST_W'(wave - W_510); recip1_in = RECIP_70;
      end else if (wave < W_645) begin
         seg1_in = SEG_YELLOW; seg_dist = DIST_W'(W_645 - wave); recip1_in = RECIP_65;
      end else begin
         seg1_in = SEG_RED;    seg_dist = '0;                    recip1_in = RECIP_90;
      end

      full1_in = 1'b0;
      fx       = '0;
      if (wave < W_420) begin
         fx = DIST_W'(wave - W_350);
      end else if (wave < W_680) begin
         full1_in = 1'b1;
      end else begin
         fx = DIST_W'(W_750 - wave);
      end
      // 3*17920 + 7*x, then times 256
      fac_sum    = FAC_BASE + (FACSUM_W'(fx) << 3) - FACSUM_W'(fx);
      facnum1_in = {fac_sum, 8'b0};
      rampx1_in  = {seg_dist, 8'b0};
   end

   assign ramp2_in = (RAMPX_W+RECIP_W)'(rampx1_ff) * (RAMPX_W+RECIP_W)'(recip1_ff);
   assign fac2_in  = (FACNUM_W+RECIP_W)'(facnum1_ff) * (FACNUM_W+RECIP_W)'(RECIP_700);

   always_comb begin
      ramp3   = INT_W'(ramp2_ff >> RECIP_SHIFT);
      fac3_in = full2_ff ? ONE_Q16 : INT_W'(fac2_ff >> RECIP_SHIFT);
      case (seg2_ff)
         SEG_VIOLET: begin
            cb3_in = ONE_Q16; cg3_in = '0;      cr3_in = ramp3;
         end
         SEG_BLUE: begin
            cb3_in = ONE_Q16; cg3_in = ramp3;   cr3_in = '0;
         end
         SEG_CYAN: begin
            cb3_in = ramp3;   cg3_in = ONE_Q16; cr3_in = '0;
         end
         SEG_GREEN: begin
            cb3_in = '0;      cg3_in = ONE_Q16; cr3_in = ramp3;
         end
         SEG_YELLOW: begin
            cb3_in = '0;      cg3_in = ramp3;   cr3_in = ONE_Q16;
         end
         default: begin
            cb3_in = '0;      cg3_in = '0;      cr3_in = ONE_Q16;
         end
      endcase
   end

   assign pb4_in = PROD_W'(cb3_ff) * PROD_W'(fac3_ff);
   assign pg4_in = PROD_W'(cg3_ff) * PROD_W'(fac3_ff);
   assign pr4_in = PROD_W'(cr3_ff) * PROD_W'(fac3_ff);

   always_comb begin
      // 255 * p as (p << 8) - p, then drop the Q32 fraction
      sb = (BYTEP_W'(pb4_ff) << 8) - BYTEP_W'(pb4_ff);
      sg = (BYTEP_W'(pg4_ff) << 8) - BYTEP_W'(pg4_ff);
      sr = (BYTEP_W'(pr4_ff) << 8) - BYTEP_W'(pr4_ff);
      blue_in  = '0;
      green_in = '0;
      red_in   = '0;
      if (!side4_ff.cont) begin
         case (side4_ff.band)
            BAND_RED:  red_in  = BYTE_MAX;
            BAND_BLUE: blue_in = BYTE_MAX;
            default:   green_in = BYTE_MAX;
         endcase
      end else if (side4_ff.in_range) begin
         blue_in  = 8'(sb >> 32);
         green_in = 8'(sg >> 32);
         red_in   = 8'(sr >> 32);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      seg1_ff    <= seg1_in;
      rampx1_ff  <= rampx1_in;
      recip1_ff  <= recip1_in;
      facnum1_ff <= facnum1_in;
      full1_ff   <= full1_in;
      side1_ff   <= in_side;
      ramp2_ff   <= ramp2_in;
      fac2_ff    <= fac2_in;
      seg2_ff    <= seg1_ff;
      full2_ff   <= full1_ff;
      side2_ff   <= side1_ff;
      cb3_ff     <= cb3_in;
      cg3_ff     <= cg3_in;
      cr3_ff     <= cr3_in;
      fac3_ff    <= fac3_in;
      side3_ff   <= side2_ff;
      pb4_ff     <= pb4_in;
      pg4_ff     <= pg4_in;
      pr4_ff     <= pr4_in;
      side4_ff   <= side3_ff;
      blue_ff    <= blue_in;
      green_ff   <= green_in;
      red_ff     <= red_in;
      last5_ff   <= side4_ff.last;
   end

   assign out_valid = valid5_ff;
   assign out_blue  = blue_ff;
   assign out_green = green_ff;
   assign out_red   = red_ff;
   assign out_last  = last5_ff;

   // every spectral segment holds one channel at full intensity
   `DTC_ASSERT_IMP(a_full_channel, clock, reset, valid3_ff, (cb3_ff == ONE_Q16) || (cg3_ff == ONE_Q16) || (cr3_ff == ONE_Q16))
   // out of range in continuous mode comes out black
   `DTC_ASSERT_NXT(a_black_out, clock, reset, valid4_ff && side4_ff.cont && !side4_ff.in_range, (out_blue == 8'h00) && (out_green == 8'h00) && (out_red == 8'h00))

endmodule

>>> bench/depth_to_color_mapper_checker.sv
// pixel checker for the depth to color mapper: predicts each request's pixel and compares
module depth_to_color_mapper_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [dtc_pkg::DEPTH_W-1:0]    req_depth,
   input  logic                           req_frame_last_in,
   input  logic                           rsp_valid,
   input  logic [7:0]                     rsp_blue,
   input  logic [7:0]                     rsp_green,
   input  logic [7:0]                     rsp_red,
   input  logic                           rsp_frame_last_out,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [dtc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dtc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    errors,
   output int unsigned                    pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dtc_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       last;
   } pixel_type;

   logic [DEPTH_W-1:0]  cfg_near;
   logic [DEPTH_W-1:0]  cfg_far;
   logic                cfg_cont;
   logic [MARGIN_W-1:0] cfg_margin;
   pixel_type           expected_pixels[$];

   function automatic pixel_type paint_depth(input logic [DEPTH_W-1:0] depth,
                                             input logic last);
      longint             d, n, f, m, lo, hi, span;
      logic [WAVE_W-1:0]  w;
      logic [WAVE_W-1:0]  x;
      logic [INT_W-1:0]   cr, cg, cb, fac;
      pixel_type          px;
      px = '0;
      px.last = last;
      d = depth;
      n = cfg_near;
      f = cfg_far;
      m = cfg_margin;
      if (cfg_cont) begin
         lo = n - 5;
         hi = f + 5;
         if (d >= lo && d <= hi) begin
            span = hi - lo;
            w = W_350;
            // zero span keeps the short end of the spectrum
            if (span != 0) w = W_350 + WAVE_W'(((d - lo) * 102400) / span);
            if (w < W_440) begin
               cr = (W_440 - w) * 256 / 90;
               cg = '0;
               cb = ONE_Q16;
            end else if (w < W_490) begin
               cr = '0;
               cg = (w - W_440) * 256 / 50;
               cb = ONE_Q16;
            end else if (w < W_510) begin
               cr = '0;
               cg = ONE_Q16;
               cb = (W_510 - w) * 256 / 20;
            end else if (w < W_580) begin
               cr = (w - W_510) * 256 / 70;
               cg = ONE_Q16;
               cb = '0;
            end else if (w < W_645) begin
               cr = ONE_Q16;
               cg = (W_645 - w) * 256 / 65;
               cb = '0;
            end else begin
               cr = ONE_Q16;
               cg = '0;
               cb = '0;
            end
            // falloff toward both ends of the spectrum
            fac = ONE_Q16;
            if (w < W_420 || w >= W_680) begin
               x = (w < W_420) ? (w - W_350) : (W_750 - w);
               fac = (FAC_BASE + 7 * x) * 256 / 700;
            end
            px.blue  = 8'((64'd255 * cb * fac) >> 32);
            px.green = 8'((64'd255 * cg * fac) >> 32);
            px.red   = 8'((64'd255 * cr * fac) >> 32);
         end
      end else begin
         if (d >= f - m) px.red = BYTE_MAX;
         else if (d <= n - m) px.blue = BYTE_MAX;
         else px.green = BYTE_MAX;
      end
      return px;
   endfunction

   always @(posedge clock) begin : watch
      pixel_type got;
      pixel_type want;
      if (reset) begin
         cfg_near   = NEAR_RST;
         cfg_far    = FAR_RST;
         cfg_cont   = MODE_RST;
         cfg_margin = MARGIN_RST;
         expected_pixels.delete();
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            got = '{blue: rsp_blue, green: rsp_green, red: rsp_red,
                    last: rsp_frame_last_out};
            if (expected_pixels.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected pixel: b=%0d g=%0d r=%0d last=%0d",
                           got.blue, got.green, got.red, got.last);
            end else begin
               want = expected_pixels.pop_front();
               if (got.blue !== want.blue || got.green !== want.green ||
                   got.red !== want.red || got.last !== want.last) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display({"pixel mismatch: expected b=%0d g=%0d r=%0d last=%0d,",
                               " got b=%0d g=%0d r=%0d last=%0d"},
                              want.blue, want.green, want.red, want.last,
                              got.blue, got.green, got.red, got.last);
               end
            end
         end
         if (start && !busy)
            expected_pixels.insert(expected_pixels.size(),
                                   paint_depth(req_depth, req_frame_last_in));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NEAR:   cfg_near   = csr_wdata[DEPTH_W-1:0];
               CSR_FAR:    cfg_far    = csr_wdata[DEPTH_W-1:0];
               CSR_MODE:   cfg_cont   = csr_wdata[0];
               CSR_MARGIN: cfg_margin = csr_wdata[MARGIN_W-1:0];
               default: ;
            endcase
         end
         pending <= expected_pixels.size();
      end
   end

endmodule

>>> bench/depth_to_color_mapper_tb.sv
// testbench top for the depth to color mapper: stimulus, settings and verdict
module depth_to_color_mapper_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtc_pkg::*;

   localparam int RANDOM_ITEMS   = 1800;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic MODE_SPECTRAL = 1'b1;
   localparam logic MODE_BANDS    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNMAPPED = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_UNMAPPED  = CSR_IDX_W'(255);

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [DEPTH_W-1:0]    req_depth;
   logic                  req_frame_last_in;
   logic                  rsp_valid;
   logic [7:0]            rsp_blue;
   logic [7:0]            rsp_green;
   logic [7:0]            rsp_red;
   logic                  rsp_frame_last_out;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           mismatch_count;
   int unsigned           pending_pixels;
   int                    stall_cycles;

   int   near_now, far_now, margin_now;
   logic mode_now;

   depth_to_color_mapper u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_depth          (req_depth),
      .req_frame_last_in  (req_frame_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_blue           (rsp_blue),
      .rsp_green          (rsp_green),
      .rsp_red            (rsp_red),
      .rsp_frame_last_out (rsp_frame_last_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   depth_to_color_mapper_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_depth          (req_depth),
      .req_frame_last_in  (req_frame_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_blue           (rsp_blue),
      .rsp_green          (rsp_green),
      .rsp_red            (rsp_red),
      .rsp_frame_last_out (rsp_frame_last_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .errors             (mismatch_count),
      .pending            (pending_pixels)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // nothing accepted or returned for too long means the block hung
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic last);
      @(negedge clock);
      start             <= 1'b1;
      req_depth         <= depth;
      req_frame_last_in <= last;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int cycles);
      @(negedge clock);
      start     <= 1'b0;
      req_depth <= DEPTH_W'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // hold requests until every pixel is back and the pipeline is empty
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_pixels != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // upper data bits are random, the block keeps only the register width
   task automatic apply_setting(input int near, input int far, input logic mode,
                                input int margin);
      drain();
      write_reg(CSR_NEAR,   {2'($urandom), DEPTH_W'(near)});
      write_reg(CSR_FAR,    {2'($urandom), DEPTH_W'(far)});
      write_reg(CSR_MODE,   {15'($urandom), mode});
      write_reg(CSR_MARGIN, {6'($urandom), MARGIN_W'(margin)});
      near_now   = near;
      far_now    = far;
      mode_now   = mode;
      margin_now = margin;
   endtask

   initial begin
      int style, near, far, count, burst_left, sent, win_lo, win_hi;
      logic [DEPTH_W-1:0] depth;
      reset             = 1'b1;
      start             = 1'b0;
      req_depth         = '0;
      req_frame_last_in = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      near_now          = NEAR_RST;
      far_now           = FAR_RST;
      mode_now          = MODE_RST;
      margin_now        = MARGIN_RST;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: 0 to 4095 sweeps the spectrum, far plus six is black
      send_pixel(0, 1'b0);
      send_pixel(4095, 1'b1);
      send_pixel(4100, 1'b0);
      send_pixel(4101, 1'b1);
      send_pixel(16383, 1'b0);
      send_pixel(2048, 1'b1);
      send_pixel(1024, 1'b0);
      // zero span, the one depth in range lands on the short end
      apply_setting(20, 10, MODE_SPECTRAL, 0);
      send_pixel(15, 1'b1);
      send_pixel(14, 1'b0);
      send_pixel(16, 1'b1);
      apply_setting(0, 16383, MODE_SPECTRAL, 1023);
      send_pixel(0, 1'b0);
      send_pixel(16383, 1'b1);
      send_pixel(8191, 1'b0);
      // inverted range, nothing is in range
      apply_setting(16383, 0, MODE_SPECTRAL, 0);
      send_pixel(16378, 1'b1);
      send_pixel(5, 1'b0);
      send_pixel(0, 1'b1);
      // band thresholds at 950 and 50
      apply_setting(100, 1000, MODE_BANDS, 50);
      send_pixel(950, 1'b0);
      send_pixel(949, 1'b1);
      send_pixel(50, 1'b0);
      send_pixel(51, 1'b1);
      send_pixel(16383, 1'b0);
      send_pixel(0, 1'b1);
      // far threshold below zero is always met
      apply_setting(0, 0, MODE_BANDS, 1023);
      send_pixel(0, 1'b0);
      apply_setting(16383, 16383, MODE_BANDS, 0);
      send_pixel(16382, 1'b1);
      send_pixel(16383, 1'b0);
      // unmapped indexes must leave the settings alone
      drain();
      write_reg(CSR_FIRST_UNMAPPED, 16'hFFFF);
      write_reg(CSR_LAST_UNMAPPED, 16'h0000);
      send_pixel(16383, 1'b1);

      sent       = 0;
      burst_left = 0;
      while (sent < RANDOM_ITEMS) begin
         style = $urandom_range(0, 3);
         near  = $urandom_range(0, 16383);
         case (style)
            0: far = near + $urandom_range(0, 3000);
            1: far = $urandom_range(0, 16383);
            2: far = near + $urandom_range(0, 40);
            default: far = near - 10 + $urandom_range(0, 2);
         endcase
         if (far > 16383) far = 16383;
         if (far < 0) far = 0;
         apply_setting(near, far, 1'($urandom_range(0, 1)), $urandom_range(0, 1023));
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_IDX_W'($urandom_range(CSR_FIRST_UNMAPPED, CSR_LAST_UNMAPPED)),
                      CSR_DATA_W'($urandom));
         // aim most depths around the colored range or the band thresholds
         win_lo = ((near_now < far_now) ? near_now : far_now) - 16;
         if (mode_now == MODE_BANDS) win_lo = win_lo - margin_now;
         win_hi = ((near_now > far_now) ? near_now : far_now) + 16;
         if (win_lo < 0) win_lo = 0;
         if (win_hi > 16383) win_hi = 16383;
         count = $urandom_range(100, 200);
         repeat (count) begin
            if (burst_left == 0) begin
               pause($urandom_range(1, 8));
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(1, 20);
            end
            if ($urandom_range(0, 7) < 2) depth = DEPTH_W'($urandom);
            else depth = DEPTH_W'($urandom_range(win_lo, win_hi));
            send_pixel(depth, 1'($urandom_range(0, 1)));
            burst_left--;
            sent++;
         end
      end

      drain();
      if (mismatch_count == 0 && pending_pixels == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/dtc_pkg.sv
rtl/dtc_front.sv
rtl/dtc_divider.sv
rtl/dtc_shade.sv
rtl/depth_to_color_mapper.sv
bench/depth_to_color_mapper_checker.sv
bench/depth_to_color_mapper_tb.sv
